[design/urd_pkg.sv]
`timescale 1ns / 1ps

package urd_pkg;

    // Widths fixed by the item fields
    localparam int VALUE_PORT_W   = 64;
    localparam int BASE_W         = 6;
    localparam int CHAR_W         = 7;

    // Default width of the converted number
    localparam int VALUE_BITS_DEF = 64;

    // Quotient bits resolved per divider cycle
    localparam int STEP_BITS      = 8;

    // Entries in the request queue between front and back
    localparam int QUEUE_DEPTH    = 2;

    // Legal radix range
    localparam logic [BASE_W-1:0] MIN_BASE  = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE  = BASE_W'(36);
    localparam logic [BASE_W-1:0] DEC_LIMIT = BASE_W'(10);

    // ASCII anchors
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0] CHAR_ERROR = '0;

    // Classification that travels with each queued request
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              bad;
    } t_job_ctl;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LOAD,
        ST_BAD
    } t_back_state;

    // Digit value to ASCII: '0'..'9' then 'A' onward
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_ALPHA + CHAR_W'(d - DEC_LIMIT);
        end
        return c;
    endfunction

endpackage

[design/urd_front.sv]
`timescale 1ns / 1ps

module urd_front #(
    parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_valid,
    input  logic [urd_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [urd_pkg::BASE_W-1:0]       i_base,
    input  logic                              i_full,
    output logic                              o_stall,
    output logic                              o_push,
    output logic [VALUE_BITS-1:0]             o_value,
    output urd_pkg::t_job_ctl                 o_ctl
);
    import urd_pkg::*;

    // Hold off requests while the queue is full
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Drop bits above the converted width
    assign o_value = i_value[VALUE_BITS-1:0];

    // Classify the radix
    always_comb begin
        o_ctl.base = i_base;
        o_ctl.bad  = (i_base < MIN_BASE) || (i_base > MAX_BASE);
    end

endmodule

[design/urd_queue.sv]
`timescale 1ns / 1ps

module urd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import urd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/urd_back.sv]
`timescale 1ns / 1ps

module urd_back #(
    parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  logic [VALUE_BITS-1:0]        i_job_value,
    input  urd_pkg::t_job_ctl            i_job_ctl,
    output logic                         o_job_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [urd_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last,
    output logic                         o_bad_base
);
    import urd_pkg::*;

    localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = CHUNKS * STEP_BITS;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IDX_W   = $clog2(VALUE_BITS);

    t_back_state         r_state, n_state;
    logic [PAD_W-1:0]    r_quo, n_quo;
    logic [BASE_W-1:0]   r_rem, n_rem;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic                r_out_bad, n_out_bad;
    logic [BASE_W-1:0]   r_rd_data;
    logic [BASE_W-1:0]   r_digits [VALUE_BITS];

    logic [STEP_BITS-1:0] div_top;
    logic [STEP_BITS-1:0] div_qbits;
    logic [BASE_W-1:0]    div_rem;
    logic [BASE_W:0]      div_trial;
    logic [PAD_W-1:0]     div_quo;
    logic                 dig_we;
    logic                 slot_free;

    // One chunk of restoring division by the radix
    always_comb begin
        div_top   = r_quo[PAD_W-1 -: STEP_BITS];
        div_rem   = r_rem;
        div_qbits = '0;
        div_trial = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            div_trial = {div_rem, div_top[i]};
            if (div_trial >= {1'b0, r_base}) begin
                div_qbits[i] = 1'b1;
                div_rem      = BASE_W'(div_trial - {1'b0, r_base});
            end else begin
                div_rem      = div_trial[BASE_W-1:0];
            end
        end
        div_quo = (r_quo << STEP_BITS) | PAD_W'(div_qbits);
    end

    assign slot_free = !r_out_valid || !i_stall;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_base      = r_base;
        n_chunk     = r_chunk;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        o_job_pop   = 1'b0;
        dig_we      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_quo     = PAD_W'(i_job_value);
                    n_rem     = '0;
                    n_base    = i_job_ctl.base;
                    n_chunk   = '0;
                    n_idx     = '0;
                    n_state   = i_job_ctl.bad ? ST_BAD : ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo   = div_quo;
                n_rem   = div_rem;
                n_chunk = r_chunk + 1'b1;
                if (r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                    // Digit done: store it, go on while the quotient is nonzero
                    dig_we  = 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                    if (div_quo == '0) begin
                        n_state = ST_RD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // Read out most significant digit first
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_to_char(r_rd_data);
                    n_out_last  = (r_idx == '0);
                    n_out_bad   = 1'b0;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            ST_BAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ERROR;
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Digit store, least significant first
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_digits[r_idx] <= div_rem;
        end
        r_rd_data <= r_digits[r_idx];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_base     <= n_base;
        r_chunk    <= n_chunk;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;
    assign o_bad_base   = r_out_bad;

    // Partial remainder stays below the radix during division
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_base))
        else $error("partial remainder not below radix");

    // Only legal radices reach the divider
    a_div_base_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_base >= MIN_BASE && r_base <= MAX_BASE))
        else $error("divider running with illegal radix");

    // An error result carries the all-zero error character and the end mark
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_last && r_out_char == CHAR_ERROR))
        else $error("malformed bad-radix result");

    // A readout with a free slot always presents a result next cycle
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && slot_free) |=> r_out_valid)
        else $error("digit readout lost");

endmodule

[design/uint_to_radix_digits.sv]
`timescale 1ns / 1ps
// Operation: the divider resolves 8 quotient bits a cycle, one digit per pass over the value,
//   then each digit is read back from the digit store MSD first (states ST_RD, ST_LOAD).
// Throughput: one request at a time in the divider; a two-entry queue takes new
//   requests meanwhile.
// Reset: synchronous, active low; clears the queue, sequencer and output valid.
module uint_to_radix_digits #(
    parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [urd_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [urd_pkg::BASE_W-1:0]       i_base,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [urd_pkg::CHAR_W-1:0]       o_digit_char,
    output logic                              o_last,
    output logic                              o_bad_base
);
    import urd_pkg::*;

    localparam int JOB_W = VALUE_BITS + $bits(t_job_ctl);

    logic                  fe_push;
    logic [VALUE_BITS-1:0] fe_value;
    t_job_ctl              fe_ctl;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [JOB_W-1:0]      q_data;
    logic [VALUE_BITS-1:0] be_value;
    t_job_ctl              be_ctl;

    // Front: accept and classify
    urd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid (i_valid),
        .i_value (i_value),
        .i_base  (i_base),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (fe_push),
        .o_value (fe_value),
        .o_ctl   (fe_ctl)
    );

    // Request queue
    urd_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_value, fe_ctl}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign be_value = q_data[JOB_W-1 -: VALUE_BITS];
    assign be_ctl   = t_job_ctl'(q_data[$bits(t_job_ctl)-1:0]);

    // Back: divide, store digits, emit
    urd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job_value  (be_value),
        .i_job_ctl    (be_ctl),
        .o_job_pop    (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_base   (o_bad_base)
    );

endmodule

[tb/radix_digit_checker.sv]
`timescale 1ns / 1ps

module radix_digit_checker #(
    parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  logic [urd_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [urd_pkg::BASE_W-1:0]       i_base,
    input  logic                             i_res_valid,
    input  logic                             i_res_stall,
    input  logic [urd_pkg::CHAR_W-1:0]       i_digit_char,
    input  logic                             i_last,
    input  logic                             i_bad_base,
    output int                               o_fail_count,
    output int                               o_digits_pending,
    output int                               o_digits_seen
);
    import urd_pkg::*;

    // Only the low VALUE_BITS of the number take part in the conversion
    localparam logic [VALUE_PORT_W-1:0] NUM_MASK = (VALUE_BITS >= VALUE_PORT_W) ?
        {VALUE_PORT_W{1'b1}} : ((VALUE_PORT_W'(1) << VALUE_BITS) - VALUE_PORT_W'(1));

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              bad_base;
    } t_digit;

    t_digit digit_q[$];
    int     fails      = 0;
    int     pending    = 0;
    int     seen       = 0;

    assign o_fail_count     = fails;
    assign o_digits_pending = pending;
    assign o_digits_seen    = seen;

    // Expected digit stream of one request, most significant digit first
    function automatic void queue_digits(input logic [VALUE_PORT_W-1:0] value,
                                         input logic [BASE_W-1:0]       base);
        logic [VALUE_PORT_W-1:0] num;
        logic [VALUE_PORT_W-1:0] radix;
        logic [VALUE_PORT_W-1:0] rem;
        logic [CHAR_W-1:0]       rev [VALUE_PORT_W];
        int                      n;
        int                      k;
        t_digit                  d;
        if (base < MIN_BASE || base > MAX_BASE) begin
            d.digit_char = CHAR_ERROR;
            d.last       = 1'b1;
            d.bad_base   = 1'b1;
            digit_q.push_back(d);
            return;
        end
        num   = value & NUM_MASK;
        radix = VALUE_PORT_W'(base);
        n     = 0;
        // Least significant digit comes out of the division first
        do begin
            rem = num % radix;
            if (rem < VALUE_PORT_W'(DEC_LIMIT)) begin
                rev[n] = CHAR_ZERO + CHAR_W'(rem);
            end else begin
                rev[n] = CHAR_ALPHA + CHAR_W'(rem - VALUE_PORT_W'(DEC_LIMIT));
            end
            n++;
            num = num / radix;
        end while (num != '0 && n < VALUE_PORT_W);
        for (k = n - 1; k >= 0; k--) begin
            d.digit_char = rev[k];
            d.last       = (k == 0);
            d.bad_base   = 1'b0;
            digit_q.push_back(d);
        end
    endfunction

    // Predict on each accepted request, compare each accepted digit
    always @(posedge i_clk) begin
        t_digit want;
        int     errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                queue_digits(i_value, i_base);
            end
            if (i_res_valid && !i_res_stall) begin
                seen <= seen + 1;
                if (digit_q.size() == 0) begin
                    $error("unexpected digit: char=%0d last=%0b bad_base=%0b",
                           i_digit_char, i_last, i_bad_base);
                    errs++;
                end else begin
                    want = digit_q.pop_front();
                    if (i_digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, i_digit_char);
                        errs++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        errs++;
                    end
                    if (i_bad_base !== want.bad_base) begin
                        $error("bad_base: expected %0b, got %0b",
                               want.bad_base, i_bad_base);
                        errs++;
                    end
                end
            end
            fails   <= fails + errs;
            pending <= digit_q.size();
        end
    end

endmodule

[tb/uint_to_radix_digits_tb.sv]
`timescale 1ns / 1ps

module uint_to_radix_digits_tb;
    import urd_pkg::*;

    localparam int VALUE_BITS  = VALUE_BITS_DEF;
    localparam int RAND_REQS   = 440;
    localparam int PHASE_LEN   = 160;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [VALUE_PORT_W-1:0] i_value;
    logic [BASE_W-1:0]       i_base;
    logic                    o_valid;
    logic                    i_stall;
    logic [CHAR_W-1:0]       o_digit_char;
    logic                    o_last;
    logic                    o_bad_base;

    int fail_count;
    int digits_pending;
    int digits_seen;
    int req_count      = 0;
    int bad_req_count  = 0;
    int send_idle_pct  = 19;
    int recv_stall_pct = 79;
    int quiet_cycles   = 0;

    uint_to_radix_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_base       (i_base),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_base   (o_bad_base)
    );

    radix_digit_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_value          (i_value),
        .i_base           (i_base),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_digit_char     (o_digit_char),
        .i_last           (o_last),
        .i_bad_base       (o_bad_base),
        .o_fail_count     (fail_count),
        .o_digits_pending (digits_pending),
        .o_digits_seen    (digits_seen)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles without any accepted request or digit
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive one request and hold it until accepted; called at a falling edge
    task automatic send_req(input logic [VALUE_PORT_W-1:0] value,
                            input logic [BASE_W-1:0]       base);
        if (req_count < PHASE_LEN) begin
            send_idle_pct  = 19;
            recv_stall_pct = 79;
        end else if (req_count < 2 * PHASE_LEN) begin
            send_idle_pct  = 79;
            recv_stall_pct = 19;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_base  <= base;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        req_count++;
        if (base < MIN_BASE || base > MAX_BASE) begin
            bad_req_count++;
        end
        @(negedge i_clk);
    endtask

    // Random number: full width, random length, small or all ones
    function automatic logic [VALUE_PORT_W-1:0] rand_value();
        logic [VALUE_PORT_W-1:0] v;
        int                      len;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: begin
                len = $urandom_range(1, VALUE_PORT_W);
                v   = v >> (VALUE_PORT_W - len);
            end
            1: begin
                v = VALUE_PORT_W'($urandom_range(0, 2000));
            end
            2: begin
                if ($urandom_range(3) == 0) begin
                    v = '1;
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // Mostly legal radix, some out of range on either side
    function automatic logic [BASE_W-1:0] rand_base();
        logic [BASE_W-1:0] b;
        if ($urandom_range(99) < 90) begin
            b = BASE_W'($urandom_range(MIN_BASE, MAX_BASE));
        end else if ($urandom_range(1) == 0) begin
            b = BASE_W'($urandom_range(0, MIN_BASE - 1));
        end else begin
            b = BASE_W'($urandom_range(MAX_BASE + 1, (1 << BASE_W) - 1));
        end
        return b;
    endfunction

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_base  = MIN_BASE;
        i_stall = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero, all ones, extreme radixes, letter digits, bad radix
        send_req('0, DEC_LIMIT);
        send_req('0, MIN_BASE);
        send_req('0, MAX_BASE);
        send_req('1, MIN_BASE);
        send_req('1, DEC_LIMIT);
        send_req('1, BASE_W'(16));
        send_req('1, MAX_BASE);
        send_req(VALUE_PORT_W'(1), MIN_BASE);
        send_req(VALUE_PORT_W'(35), MAX_BASE);
        send_req(VALUE_PORT_W'(36), MAX_BASE);
        send_req(VALUE_PORT_W'(10), BASE_W'(11));
        send_req(VALUE_PORT_W'(9), DEC_LIMIT);
        send_req({1'b1, {(VALUE_PORT_W-1){1'b0}}}, MIN_BASE);
        send_req(64'h0123_4567_89AB_CDEF, BASE_W'(16));
        send_req(64'hFEDC_BA98_7654_3210, BASE_W'(3));
        send_req('0, BASE_W'(0));
        send_req(rand_value(), BASE_W'(0));
        send_req(rand_value(), BASE_W'(1));
        send_req(rand_value(), BASE_W'(37));
        send_req('1, BASE_W'(63));

        // Random requests across all three pacing phases
        repeat (RAND_REQS) begin
            send_req(rand_value(), rand_base());
        end
        i_valid <= 1'b0;

        // Drain, then watch for stray digits
        while (digits_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d requests (%0d with an illegal radix) into %0d digits,",
                 req_count, bad_req_count, digits_seen);
        $display("under sender gaps, receiver stalls and full-rate streaming.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
